/* rtl/core/ecal_pkg.sv */
// ecal_pkg: constants and calendar tables for the epoch-to-calendar pipeline
// no dependencies
`default_nettype none
package ecal_pkg;
  // reciprocal multipliers for exact division by constants
  localparam logic [31:0] MAGIC60   = 32'h8888_8889;
  localparam int          SHIFT60   = 37;
  localparam logic [31:0] MAGIC24   = 32'hAAAA_AAAB;
  localparam int          SHIFT24   = 36;
  localparam logic [17:0] MAGIC7    = 18'd149797;
  localparam logic [15:0] MAGIC1461 = 16'd45934;

  // calendar constants
  localparam logic [9:0]  DAYS_1968_1969 = 10'd731;
  localparam logic [15:0] MAR1_2100      = 16'd47541;
  localparam logic [2:0]  EPOCH_WEEKDAY  = 3'd4;
  localparam logic [10:0] DAYS_PER_QUAD  = 11'd1461;
  localparam logic [7:0]  YEAR_1968      = 8'd68;
  localparam logic [7:0]  YEAR_2100      = 8'd200;

  // first day of year for each year slot in a four-year group (slot 0 leap)
  function automatic logic [10:0] quad_year_start(input logic [1:0] y);
    case (y)
      2'd0:    quad_year_start = 11'd0;
      2'd1:    quad_year_start = 11'd366;
      2'd2:    quad_year_start = 11'd731;
      default: quad_year_start = 11'd1096;
    endcase
  endfunction

  // first day of year of each month
  function automatic logic [8:0] month_start(input logic leap, input logic [3:0] m);
    logic [8:0] base;
    case (m)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      default: base = 9'd334;
    endcase
    month_start = (leap && m >= 4'd2) ? base + 9'd1 : base;
  endfunction
endpackage
`default_nettype wire

/* rtl/core/ecal_tod.sv */
// ecal_tod: four-stage split of seconds into second, minute, hour and day count
// depends on ecal_pkg
`default_nettype none
module ecal_tod (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire logic [31:0] epoch_seconds,
  output logic             valid4,
  output logic [15:0]      days4,
  output logic [5:0]       sec4,
  output logic [5:0]       min4,
  output logic [4:0]       hour4
);
  logic        valid1, valid2, valid3;
  logic [31:0] t1;
  logic [63:0] prod1;
  logic [26:0] q2;
  logic [5:0]  sec2, sec3;
  logic [63:0] prod2;
  logic [20:0] m3;
  logic [5:0]  min3;
  logic [52:0] prod3;

  logic [26:0] q1_c;
  logic [20:0] m_c;
  logic [15:0] d_c;

  assign q1_c = prod1[63:ecal_pkg::SHIFT60];
  assign m_c  = prod2[57:ecal_pkg::SHIFT60];
  assign d_c  = prod3[51:ecal_pkg::SHIFT24];

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid2 <= 1'b0;
      valid3 <= 1'b0;
      valid4 <= 1'b0;
    end else if (en) begin
      valid1 <= in_valid;
      valid2 <= valid1;
      valid3 <= valid2;
      valid4 <= valid3;
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: reciprocal product for seconds / 60
      t1    <= epoch_seconds;
      prod1 <= 64'(epoch_seconds) * 64'(ecal_pkg::MAGIC60);
      // stage 2: second, and product for minutes / 60
      q2    <= q1_c;
      sec2  <= 6'(t1 - 32'(q1_c) * 32'd60);
      prod2 <= 64'(q1_c) * 64'(ecal_pkg::MAGIC60);
      // stage 3: minute, and product for hours / 24
      m3    <= m_c;
      min3  <= 6'(q2 - 27'(m_c) * 27'd60);
      sec3  <= sec2;
      prod3 <= 53'(m_c) * 53'(ecal_pkg::MAGIC24);
      // stage 4: hour and day count
      days4 <= d_c;
      hour4 <= 5'(m3 - 21'(d_c) * 21'd24);
      min4  <= min3;
      sec4  <= sec3;
    end
  end
endmodule
`default_nettype wire

/* rtl/core/ecal_date.sv */
// ecal_date: four-stage conversion of day count to weekday, year, day of year and month
// depends on ecal_pkg
`default_nettype none
module ecal_date (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire logic [15:0] days,
  input  wire logic [5:0]  sec_in,
  input  wire logic [5:0]  min_in,
  input  wire logic [4:0]  hour_in,
  output logic             valid8,
  output logic [5:0]       second,
  output logic [5:0]       minute,
  output logic [4:0]       hour,
  output logic [2:0]       weekday,
  output logic [7:0]       years_since_1900,
  output logic [8:0]       day_of_year,
  output logic [3:0]       month_index,
  output logic [4:0]       day_of_month
);
  logic        valid5, valid6, valid7;
  logic [5:0]  sec5, sec6, sec7, min5, min6, min7;
  logic [4:0]  hour5, hour6, hour7;
  logic [16:0] wsum5;
  logic [34:0] wprod5;
  logic [16:0] dq5;
  logic [32:0] qprod5;
  logic        bump5, bump6;
  logic [2:0]  wday6, wday7;
  logic [5:0]  quad6;
  logic [10:0] r6;
  logic [8:0]  yday7, yday_out7;
  logic        leap7;
  logic [7:0]  year7;

  logic        bump_c;
  logic [16:0] dq_c;
  logic [14:0] wq_c;
  logic [5:0]  quad_c;
  logic [1:0]  y_c;
  logic [8:0]  yday_c;
  logic [7:0]  year_c;
  logic [3:0]  month_c;

  // treat 2100 as leap so four-year groups stay regular, then fix day of year
  assign bump_c = (days >= ecal_pkg::MAR1_2100);
  assign dq_c   = 17'(days) + 17'(ecal_pkg::DAYS_1968_1969) + 17'(bump_c);
  assign wq_c   = wprod5[34:20];
  assign quad_c = qprod5[31:26];
  assign y_c    = 2'(r6 >= 11'd366) + 2'(r6 >= 11'd731) + 2'(r6 >= 11'd1096);
  assign yday_c = 9'(r6 - ecal_pkg::quad_year_start(y_c));
  assign year_c = ecal_pkg::YEAR_1968 + {quad6, 2'b00} + 8'(y_c);

  // month is the count of month starts at or below the day of year
  always_comb begin
    month_c = 4'd0;
    for (int m = 1; m < 12; m++) begin
      if (yday7 >= ecal_pkg::month_start(leap7, 4'(m))) month_c = 4'(m);
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      valid5 <= 1'b0;
      valid6 <= 1'b0;
      valid7 <= 1'b0;
      valid8 <= 1'b0;
    end else if (en) begin
      valid5 <= in_valid;
      valid6 <= valid5;
      valid7 <= valid6;
      valid8 <= valid7;
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    if (en) begin
      // stage 5: reciprocal products for weekday and four-year group
      wsum5  <= 17'(days) + 17'(ecal_pkg::EPOCH_WEEKDAY);
      wprod5 <= 35'(days + 17'(ecal_pkg::EPOCH_WEEKDAY)) * 35'(ecal_pkg::MAGIC7);
      dq5    <= dq_c;
      qprod5 <= 33'(dq_c) * 33'(ecal_pkg::MAGIC1461);
      bump5  <= bump_c;
      sec5   <= sec_in;
      min5   <= min_in;
      hour5  <= hour_in;
      // stage 6: weekday, group index and day within group
      wday6  <= 3'(wsum5 - 17'(wq_c) * 17'd7);
      quad6  <= quad_c;
      r6     <= 11'(dq5 - 17'(quad_c) * 17'(ecal_pkg::DAYS_PER_QUAD));
      bump6  <= bump5;
      sec6   <= sec5;
      min6   <= min5;
      hour6  <= hour5;
      // stage 7: year and day of year
      yday7     <= yday_c;
      leap7     <= (y_c == 2'd0);
      year7     <= year_c;
      yday_out7 <= yday_c - 9'(bump6 && (year_c == ecal_pkg::YEAR_2100));
      wday7     <= wday6;
      sec7      <= sec6;
      min7      <= min6;
      hour7     <= hour6;
      // stage 8: month and day of month
      month_index      <= month_c;
      day_of_month     <= 5'(yday7 - ecal_pkg::month_start(leap7, month_c) + 9'd1);
      day_of_year      <= yday_out7;
      years_since_1900 <= year7;
      weekday          <= wday7;
      second           <= sec7;
      minute           <= min7;
      hour             <= hour7;
    end
  end
endmodule
`default_nettype wire

/* rtl/core/epoch_seconds_to_calendar.sv */
// Converts a 32-bit count of seconds since 1970-01-01 UTC into broken-down UTC time
// (second, minute, hour, weekday, year - 1900, day of year, month, day of month).
// Eight register stages: four split the time of day with reciprocal multipliers, four
// resolve weekday, year and month from the day count. One word enters per cycle, but
// the whole pipeline holds while out_stall is high with a result waiting. No state
// beyond the pipeline; every input value is valid.
// depends on ecal_pkg, ecal_tod, ecal_date
`default_nettype none
module epoch_seconds_to_calendar (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] epoch_seconds,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [5:0]       second,
  output logic [5:0]       minute,
  output logic [4:0]       hour,
  output logic [2:0]       weekday,
  output logic [7:0]       years_since_1900,
  output logic [8:0]       day_of_year,
  output logic [3:0]       month_index,
  output logic [4:0]       day_of_month
);
  logic        en;
  logic        valid4;
  logic [15:0] days4;
  logic [5:0]  sec4, min4;
  logic [4:0]  hour4;

  // pipeline advances unless a finished word is held
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  ecal_tod u_tod (
    .clk, .rst, .en, .in_valid, .epoch_seconds,
    .valid4, .days4, .sec4, .min4, .hour4
  );

  ecal_date u_date (
    .clk, .rst, .en, .in_valid(valid4), .days(days4),
    .sec_in(sec4), .min_in(min4), .hour_in(hour4),
    .valid8(out_valid), .second, .minute, .hour, .weekday,
    .years_since_1900, .day_of_year, .month_index, .day_of_month
  );

`ifndef ASSERT_OFF
  a_time_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (second < 6'd60 && minute < 6'd60 && hour < 5'd24 && weekday < 3'd7))
    else $error("time field out of range");
  a_date_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (month_index < 4'd12 && day_of_month != 5'd0 && day_of_year < 9'd366
                   && years_since_1900 >= 8'd70 && years_since_1900 <= 8'd206))
    else $error("date field out of range");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(day_of_year) && $stable(second))
    else $error("held word changed");
`endif
endmodule
`default_nettype wire

/* tb/epoch_seconds_to_calendar_test.sv */
// epoch_seconds_to_calendar_test: self-checking bench for the epoch-to-calendar converter
// drives seconds words with random gaps and stalls, checks every result against a predictor or a typed-in expectation
// depends on epoch_seconds_to_calendar (and ecal_pkg, ecal_tod, ecal_date through it)
`default_nettype none
module epoch_seconds_to_calendar_test;
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] epoch_seconds = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [5:0]  second, minute;
  logic [4:0]  hour;
  logic [2:0]  weekday;
  logic [7:0]  years_since_1900;
  logic [8:0]  day_of_year;
  logic [3:0]  month_index;
  logic [4:0]  day_of_month;

  typedef struct packed {
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hr;
    logic [2:0] wday;
    logic [7:0] year;
    logic [8:0] yday;
    logic [3:0] mon;
    logic [4:0] mday;
  } utc_fields_t;

  // directed row: input, and an optional typed-in expectation
  typedef struct {
    logic [31:0] secs;
    bit          has_known;
    utc_fields_t known;
  } stim_row_t;

  localparam int N_RANDOM  = 1830;
  localparam int CYC_LIMIT = 400000;

  utc_fields_t pending_dates[$];
  int mismatches = 0;
  int results_seen = 0;
  int cycles = 0;
  bit stim_done = 1'b0;

  epoch_seconds_to_calendar i_dut (
    .clk, .rst, .in_valid, .in_stall, .epoch_seconds, .out_valid, .out_stall,
    .second, .minute, .hour, .weekday, .years_since_1900, .day_of_year,
    .month_index, .day_of_month
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit gregorian_leap(int y);
    if (y % 4 != 0) return 1'b0;
    if (y % 100 != 0) return 1'b1;
    return (y % 400 == 0);
  endfunction

  // break seconds down into utc calendar fields
  function automatic utc_fields_t gmt_breakdown(logic [31:0] secs);
    utc_fields_t r;
    longint t;
    int days, y, ylen, rest, m, mlen;
    int mlens[12];
    t = secs;
    mlens = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    r.sec = 6'(t % 60); t = t / 60;
    r.min = 6'(t % 60); t = t / 60;
    r.hr  = 5'(t % 24);
    days  = int'(t / 24);
    r.wday = 3'((days + 4) % 7);
    y = 1970;
    rest = days;
    forever begin
      ylen = gregorian_leap(y) ? 366 : 365;
      if (rest < ylen) break;
      rest -= ylen;
      y++;
    end
    r.year = 8'(y - 1900);
    r.yday = 9'(rest);
    m = 0;
    while (m < 11) begin
      mlen = (m == 1 && gregorian_leap(y)) ? 29 : mlens[m];
      if (rest < mlen) break;
      rest -= mlen;
      m++;
    end
    r.mon = 4'(m);
    r.mday = 5'(rest + 1);
    return r;
  endfunction

  function automatic stim_row_t row(logic [31:0] s, bit k = 0, utc_fields_t e = '0);
    stim_row_t r;
    r.secs = s; r.has_known = k; r.known = e;
    return r;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_word(logic [31:0] s, utc_fields_t e);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    epoch_seconds <= s;
    pending_dates.push_back(e);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stimulus
  initial begin
    stim_row_t rows[$];
    logic [31:0] s;
    int p;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    rows.push_back(row(32'd0, 1, '{0, 0, 0, 4, 70, 0, 0, 1}));
    rows.push_back(row(32'hFFFF_FFFF, 1, '{15, 28, 6, 0, 206, 37, 1, 7}));
    rows.push_back(row(32'd59, 1, '{59, 0, 0, 4, 70, 0, 0, 1}));
    rows.push_back(row(32'd86399, 1, '{59, 59, 23, 4, 70, 0, 0, 1}));
    rows.push_back(row(32'd86400));
    rows.push_back(row(32'd31535999));          // end of 1970
    rows.push_back(row(32'd31536000));          // start of 1971
    rows.push_back(row(32'd68169600));          // 1972-02-29, first leap day
    rows.push_back(row(32'd951782400));         // 2000-02-29, leap century
    rows.push_back(row(32'd951868800));         // 2000-03-01
    rows.push_back(row(32'd978220800));         // 2000-12-31, day 365
    rows.push_back(row(32'd4107542399));        // 2100-02-28 23:59:59
    rows.push_back(row(32'd4107542400));        // 2100-03-01, not leap
    rows.push_back(row(32'd4133894399));        // 2100-12-30 23:59:59
    rows.push_back(row(32'h7FFF_FFFF));
    rows.push_back(row(32'h8000_0000));
    rows.push_back(row(32'hAAAA_AAAA));
    rows.push_back(row(32'h5555_5555));
    foreach (rows[i])
      send_word(rows[i].secs,
                rows[i].has_known ? rows[i].known : gmt_breakdown(rows[i].secs));
    // random part: uniform words plus words near day edges and near the top of the range
    for (int n = 0; n < N_RANDOM; n++) begin
      p = $urandom_range(0, 9);
      if (p < 6) s = $urandom;
      else if (p < 8) s = ($urandom_range(0, 49709) * 86400) + $urandom_range(0, 2)
                          - (p == 7 ? 32'd1 : 32'd0);
      else s = 32'hFFFF_FFFF - $urandom_range(0, 200000);
      send_word(s, gmt_breakdown(s));
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // random receiver stalls with quiet stretches
  initial begin
    int g;
    forever begin
      @(posedge clk);
      g = gap_len();
      if (g > 0 && $urandom_range(0, 3) != 0) begin
        out_stall <= 1'b1;
        repeat (g) @(posedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  // compare each word with the oldest prediction
  always @(posedge clk) begin
    utc_fields_t want, got;
    if (!rst && out_valid && !out_stall) begin
      got = '{second, minute, hour, weekday, years_since_1900, day_of_year,
              month_index, day_of_month};
      results_seen++;
      if (pending_dates.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: %p", got);
      end else begin
        want = pending_dates.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  // end of run and timeout
  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYC_LIMIT) begin
        $display("timeout after %0d cycles, %0d words pending", cycles, pending_dates.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
      if (stim_done && pending_dates.size() == 0) break;
    end
    repeat (20) @(posedge clk);
    $display("converted %0d words: directed epoch, leap and century edges, then random times",
             results_seen);
    $display("%0d mismatches over %0d cycles", mismatches, cycles);
    if (mismatches == 0 && pending_dates.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire
